@@ hdl/prm_pkg.sv @@
// Shared constants and controller/datapath interface types for the packet rate meter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package prm_pkg;

    // Ring length per stream and number of independent meters.
    localparam int WINDOW  = 10;
    localparam int STREAMS = 2;

    // Field widths of the request and result.
    localparam int SID_W   = 1;
    localparam int LEN_W   = 16;
    localparam int TIME_W  = 32;
    localparam int INST_W  = 29;
    localparam int AVG_W   = 33;
    localparam int TOTAL_W = 64;

    // Bits per second from bytes per millisecond.
    localparam int SCALE   = 8000;
    localparam int SCALE_W = 13;

    // Internal widths derived from the window and stream count.
    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int SUM_W      = SLOT_W + LEN_W;
    localparam int DVD_W      = SUM_W + SCALE_W;
    localparam int CNT_W      = $clog2(DVD_W);
    localparam int RING_DEPTH = STREAMS * WINDOW;
    localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RING_W     = LEN_W + TIME_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture an accepted request
        logic rd_old;     // read the ring entry about to be overwritten
        logic update;     // update stream state and write the ring
        logic start_inst; // start the instantaneous division, read the oldest time
        logic save_inst;  // store the instantaneous quotient
        logic start_avg;  // start the average division
        logic save_avg;   // store the average quotient
        logic push;       // load the output register
    } t_prm_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drop;       // captured request gives no result
        logic div_done;   // divider finished this cycle
        logic out_free;   // output register can take a new result
    } t_prm_sts;

endpackage

`default_nettype wire

@@ hdl/packet_rate_meter_unit.sv @@
// Packet rate meter: each request passes through the controller states CHECK, OLD,
// INST, INST_W, AVG, AVG_W and OUT, with two passes of the shared
// one-bit-per-cycle divider. One request is in work at a time, so a new request is
// only taken after the last result has been loaded into the output register;
// zero-length requests are dropped in CHECK and give no result.
// Reset clears the controller, the output valid flag and all per-stream counters. The
// sample ring is not cleared; an entry's contents are only used after it has been written.
`default_nettype none

module packet_rate_meter_unit import prm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [SID_W-1:0]   i_stream_id,
    input  wire logic [LEN_W-1:0]   i_packet_bytes,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [SID_W-1:0]        o_stream_out,
    output logic [INST_W-1:0]       o_instant_bps,
    output logic [AVG_W-1:0]        o_average_bps,
    output logic [LEN_W-1:0]        o_length_echo,
    output logic [TOTAL_W-1:0]      o_total_bytes
);

    t_prm_cmd w_cmd;
    t_prm_sts w_sts;

    // Sequencer.
    prm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // State, ring, divider and output register.
    prm_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_stream_id    (i_stream_id),
        .i_packet_bytes (i_packet_bytes),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_stream_out   (o_stream_out),
        .o_instant_bps  (o_instant_bps),
        .o_average_bps  (o_average_bps),
        .o_length_echo  (o_length_echo),
        .o_total_bytes  (o_total_bytes)
    );

endmodule

`default_nettype wire

@@ hdl/prm_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on prm_pkg for the dividend and divisor widths.
`default_nettype none

module prm_divider import prm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DVD_W-1:0]  i_dividend,
    input  wire logic [TIME_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [DVD_W-1:0]       o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [TIME_W-1:0] r_dvs;

    logic [TIME_W:0]   w_shift;
    logic [TIME_W+1:0] w_diff;
    logic              w_ge;

    // Trial subtraction of one quotient bit.
    always_comb begin
        w_shift = {r_rem, r_quo[DVD_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
        w_ge    = !w_diff[TIME_W+1];
    end

    // Control of the iteration count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[TIME_W-1:0] : w_shift[TIME_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ hdl/prm_datapath.sv @@
// Datapath of the packet rate meter: per-stream state, sample ring, divider and output register.
// Depends on prm_pkg and prm_divider; driven by prm_ctrl through t_prm_cmd.
`default_nettype none

module prm_datapath import prm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_prm_cmd           i_cmd,
    output t_prm_sts                o_sts,
    input  wire logic [SID_W-1:0]   i_stream_id,
    input  wire logic [LEN_W-1:0]   i_packet_bytes,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [SID_W-1:0]        o_stream_out,
    output logic [INST_W-1:0]       o_instant_bps,
    output logic [AVG_W-1:0]        o_average_bps,
    output logic [LEN_W-1:0]        o_length_echo,
    output logic [TOTAL_W-1:0]      o_total_bytes
);

    localparam int EXT_W = (DVD_W > AVG_W) ? DVD_W : AVG_W;
    localparam logic [EXT_W-1:0] AVG_MAX = EXT_W'({AVG_W{1'b1}});

    // Captured request.
    logic [SID_W-1:0]  r_sid;
    logic [LEN_W-1:0]  r_len;
    logic [TIME_W-1:0] r_now;

    // Per-stream state.
    logic [SLOT_W-1:0]  r_wslot [STREAMS];
    logic [FILL_W-1:0]  r_fill  [STREAMS];
    logic [TOTAL_W-1:0] r_total [STREAMS];
    logic [TIME_W-1:0]  r_prev  [STREAMS];
    logic [SUM_W-1:0]   r_wsum  [STREAMS];

    // Sample ring, {length, timestamp} per entry.
    logic [RING_W-1:0] r_ring [RING_DEPTH];
    logic [RING_W-1:0] r_rdata;

    // Intermediate results of one request.
    logic [FILL_W-1:0]  r_fill_new;
    logic [SUM_W-1:0]   r_sum_new;
    logic [ADDR_W-1:0]  r_oldest;
    logic [TIME_W-1:0]  r_elapsed;
    logic               r_inst_zero;
    logic               r_avg_zero;
    logic [TOTAL_W-1:0] r_total_new;
    logic [DVD_W-1:0]   r_inst_dvd;
    logic [DVD_W-1:0]   r_avg_dvd;
    logic [INST_W-1:0]  r_inst;
    logic [AVG_W-1:0]   r_avg;

    // Output register.
    logic               r_out_valid;
    logic [SID_W-1:0]   r_out_sid;
    logic [INST_W-1:0]  r_out_inst;
    logic [AVG_W-1:0]   r_out_avg;
    logic [LEN_W-1:0]   r_out_len;
    logic [TOTAL_W-1:0] r_out_total;

    logic               w_full;
    logic [LEN_W-1:0]   w_old_len;
    logic [SUM_W-1:0]   w_sum_next;
    logic [SLOT_W-1:0]  w_slot_next;
    logic [FILL_W-1:0]  w_fill_next;
    logic [TIME_W-1:0]  w_elapsed;
    logic [ADDR_W-1:0]  w_base;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [ADDR_W-1:0]  w_oldest;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [INST_W-1:0]  w_len_prod;
    logic [TIME_W-1:0]  w_span;
    logic               w_div_start;
    logic [DVD_W-1:0]   w_div_dvd;
    logic [TIME_W-1:0]  w_div_dvs;
    logic               w_div_done;
    logic [DVD_W-1:0]   w_div_quo;
    logic [EXT_W-1:0]   w_quo_ext;

    // Next stream state for the captured request.
    always_comb begin
        w_full      = (r_fill[r_sid] == FILL_W'(WINDOW));
        w_old_len   = r_rdata[RING_W-1 -: LEN_W];
        w_sum_next  = w_full ? r_wsum[r_sid] - SUM_W'(w_old_len) + SUM_W'(r_len)
                             : r_wsum[r_sid] + SUM_W'(r_len);
        w_slot_next = (r_wslot[r_sid] == SLOT_W'(WINDOW - 1)) ? '0 : r_wslot[r_sid] + 1'b1;
        w_fill_next = w_full ? r_fill[r_sid] : r_fill[r_sid] + 1'b1;
        w_elapsed   = r_now - r_prev[r_sid];
        w_base      = ADDR_W'(r_sid) * ADDR_W'(WINDOW);
        w_wr_addr   = w_base + ADDR_W'(r_wslot[r_sid]);
        w_oldest    = (w_fill_next == FILL_W'(WINDOW)) ? w_base + ADDR_W'(w_slot_next) : w_base;
        w_rd_addr   = i_cmd.rd_old ? w_wr_addr : r_oldest;
        w_len_prod  = INST_W'(r_len) * INST_W'(SCALE);
        w_span      = r_now - r_rdata[TIME_W-1:0];
    end

    // Divider operand selection.
    always_comb begin
        w_div_start = i_cmd.start_inst || i_cmd.start_avg;
        w_div_dvd   = i_cmd.start_inst ? r_inst_dvd : r_avg_dvd;
        w_div_dvs   = i_cmd.start_inst ? r_elapsed : w_span;
        w_quo_ext   = EXT_W'(w_div_quo);
    end

    prm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Sample ring: one write and one read port, registered read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ring[w_wr_addr] <= {r_len, r_now};
        end
        if (i_cmd.rd_old || i_cmd.start_inst) begin
            r_rdata <= r_ring[w_rd_addr];
        end
    end

    // Per-stream state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STREAMS; s++) begin
                r_wslot[s] <= '0;
                r_fill[s]  <= '0;
                r_total[s] <= '0;
                r_prev[s]  <= '0;
                r_wsum[s]  <= '0;
            end
        end else if (i_cmd.update) begin
            r_wslot[r_sid] <= w_slot_next;
            r_fill[r_sid]  <= w_fill_next;
            r_total[r_sid] <= r_total[r_sid] + TOTAL_W'(r_len);
            r_prev[r_sid]  <= r_now;
            r_wsum[r_sid]  <= w_sum_next;
        end
    end

    // Request capture and intermediate results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sid <= i_stream_id;
            r_len <= i_packet_bytes;
            r_now <= i_now_ms;
        end
        if (i_cmd.update) begin
            r_fill_new  <= w_fill_next;
            r_sum_new   <= w_sum_next;
            r_oldest    <= w_oldest;
            r_elapsed   <= w_elapsed;
            r_inst_zero <= (r_prev[r_sid] == '0) || (w_elapsed == '0);
            r_total_new <= r_total[r_sid] + TOTAL_W'(r_len);
            r_inst_dvd  <= DVD_W'(w_len_prod);
        end
        if (i_cmd.start_inst) begin
            r_avg_dvd <= DVD_W'(r_sum_new) * DVD_W'(SCALE);
        end
        if (i_cmd.start_avg) begin
            r_avg_zero <= (w_span == '0);
        end
        if (i_cmd.save_inst) begin
            r_inst <= r_inst_zero ? '0 : w_div_quo[INST_W-1:0];
        end
        // A single sample reports the instantaneous rate; large averages saturate.
        if (i_cmd.save_avg) begin
            if (r_fill_new == FILL_W'(1)) begin
                r_avg <= AVG_W'(r_inst);
            end else if (r_avg_zero) begin
                r_avg <= '0;
            end else if (w_quo_ext > AVG_MAX) begin
                r_avg <= '1;
            end else begin
                r_avg <= w_quo_ext[AVG_W-1:0];
            end
        end
    end

    // Output register holds the result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_sid   <= r_sid;
            r_out_inst  <= r_inst;
            r_out_avg   <= r_avg;
            r_out_len   <= r_len;
            r_out_total <= r_total_new;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_sts.drop     = (r_len == '0) || (32'(r_sid) >= 32'(STREAMS));
        o_sts.div_done = w_div_done;
        o_sts.out_free = !r_out_valid || i_ready;
    end

    assign o_valid       = r_out_valid;
    assign o_stream_out  = r_out_sid;
    assign o_instant_bps = r_out_inst;
    assign o_average_bps = r_out_avg;
    assign o_length_echo = r_out_len;
    assign o_total_bytes = r_out_total;

endmodule

`default_nettype wire

@@ hdl/prm_ctrl.sv @@
// Controller state machine of the packet rate meter.
// Depends on prm_pkg; sequences prm_datapath through t_prm_cmd and t_prm_sts.
`default_nettype none

module prm_ctrl import prm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_prm_sts i_sts,
    output t_prm_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_OLD,
        S_INST,
        S_INST_W,
        S_AVG,
        S_AVG_W,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_ready;

    // Commands follow combinationally from the state, the request valid and the datapath status.
    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = i_valid && r_ready;
        o_cmd.rd_old     = (r_state == S_CHECK) && !i_sts.drop;
        o_cmd.update     = (r_state == S_OLD);
        o_cmd.start_inst = (r_state == S_INST);
        o_cmd.save_inst  = (r_state == S_INST_W) && i_sts.div_done;
        o_cmd.start_avg  = (r_state == S_AVG);
        o_cmd.save_avg   = (r_state == S_AVG_W) && i_sts.div_done;
        o_cmd.push       = (r_state == S_OUT) && i_sts.out_free;
    end

    // State register and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && r_ready) begin
                        r_state <= S_CHECK;
                        r_ready <= 1'b0;
                    end
                end
                S_CHECK: begin
                    if (i_sts.drop) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end else begin
                        r_state <= S_OLD;
                    end
                end
                S_OLD: begin
                    r_state <= S_INST;
                end
                S_INST: begin
                    r_state <= S_INST_W;
                end
                S_INST_W: begin
                    if (i_sts.div_done) begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    r_state <= S_AVG_W;
                end
                S_AVG_W: begin
                    if (i_sts.div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_ready = r_ready;

endmodule

`default_nettype wire

@@ dv/prm_rate_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for packet_rate_meter_unit: watches both channels and predicts each report.
// Depends on prm_pkg for field widths, window length and stream count.
module prm_rate_checker import prm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    input  wire logic               i_req_ready,
    input  wire logic [SID_W-1:0]   i_req_stream,
    input  wire logic [LEN_W-1:0]   i_req_bytes,
    input  wire logic [TIME_W-1:0]  i_req_now,
    input  wire logic               i_rsp_valid,
    input  wire logic               i_rsp_ready,
    input  wire logic [SID_W-1:0]   i_rsp_stream,
    input  wire logic [INST_W-1:0]  i_rsp_instant,
    input  wire logic [AVG_W-1:0]   i_rsp_average,
    input  wire logic [LEN_W-1:0]   i_rsp_length,
    input  wire logic [TOTAL_W-1:0] i_rsp_total,
    output int                      o_error_count,
    output int                      o_pending
);

    localparam logic [63:0] AVG_CEIL = (64'd1 << AVG_W) - 64'd1;

    typedef struct packed {
        logic [SID_W-1:0]   stream;
        logic [INST_W-1:0]  instant;
        logic [AVG_W-1:0]   average;
        logic [LEN_W-1:0]   length;
        logic [TOTAL_W-1:0] total;
    } t_rate_report;

    // Per-stream meter state kept by the predictor.
    logic [LEN_W-1:0]   len_ring   [STREAMS][WINDOW];
    logic [TIME_W-1:0]  stamp_ring [STREAMS][WINDOW];
    int unsigned        slot_next  [STREAMS];
    int unsigned        fill       [STREAMS];
    logic [TOTAL_W-1:0] bytes_seen [STREAMS];
    logic [TIME_W-1:0]  last_stamp [STREAMS];

    t_rate_report expected_reports[$];
    t_rate_report want;
    int           mismatches = 0;

    task automatic report_mismatch(input string detail);
        $display("[%0t] MISMATCH: %s", $time, detail);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
    endtask

    // Updates one stream's meter with an accepted packet and queues its report.
    function automatic void meter_packet(input logic [SID_W-1:0] sid,
                                         input logic [LEN_W-1:0] len,
                                         input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] span;
        logic [63:0]       inst;
        logic [63:0]       avg;
        logic [63:0]       sum;
        int unsigned       oldest;
        int unsigned       k;
        t_rate_report      rpt;

        // Rate since the previous packet; zero with no usable previous stamp.
        inst = 64'd0;
        if (last_stamp[sid] != '0) begin
            elapsed = now - last_stamp[sid];
            if (elapsed != '0)
                inst = (64'(len) * 64'(SCALE)) / 64'(elapsed);
        end

        bytes_seen[sid] += 64'(len);

        // Store the sample and advance the ring.
        len_ring[sid][slot_next[sid]]   = len;
        stamp_ring[sid][slot_next[sid]] = now;
        slot_next[sid] = (slot_next[sid] + 1) % WINDOW;
        if (fill[sid] < WINDOW)
            fill[sid]++;

        // Windowed average over the stored samples.
        avg = 64'd0;
        if (fill[sid] > 1) begin
            oldest = (fill[sid] == WINDOW) ? slot_next[sid] : 0;
            span   = now - stamp_ring[sid][oldest];
            sum    = 64'd0;
            for (k = 0; k < fill[sid]; k++)
                sum += 64'(len_ring[sid][k]);
            if (span != '0) begin
                avg = (sum * 64'(SCALE)) / 64'(span);
                if (avg > AVG_CEIL)
                    avg = AVG_CEIL;
            end
        end else begin
            avg = inst;
        end

        last_stamp[sid] = now;

        rpt.stream  = sid;
        rpt.instant = inst[INST_W-1:0];
        rpt.average = avg[AVG_W-1:0];
        rpt.length  = len;
        rpt.total   = bytes_seen[sid];
        expected_reports.push_back(rpt);
    endfunction

    // Predict on accepted requests and compare on accepted results.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STREAMS; s++) begin
                slot_next[s]  = 0;
                fill[s]       = 0;
                bytes_seen[s] = '0;
                last_stamp[s] = '0;
            end
            expected_reports.delete();
        end else begin
            if (i_req_valid && i_req_ready && i_req_bytes != '0 && i_req_stream < STREAMS)
                meter_packet(i_req_stream, i_req_bytes, i_req_now);
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with no request waiting");
                end else begin
                    want = expected_reports.pop_front();
                    check_field("stream_out", 64'(i_rsp_stream), 64'(want.stream));
                    check_field("instant_bps", 64'(i_rsp_instant), 64'(want.instant));
                    check_field("average_bps", 64'(i_rsp_average), 64'(want.average));
                    check_field("length_echo", 64'(i_rsp_length), 64'(want.length));
                    check_field("total_bytes", i_rsp_total, want.total);
                end
            end
        end
        o_pending     <= expected_reports.size();
        o_error_count <= mismatches;
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the packet rate meter testbench: clock, reset, stimulus and the verdict.
// Depends on prm_pkg, packet_rate_meter_unit and prm_rate_checker.
module tb_top;
    import prm_pkg::*;

    localparam int RANDOM_PACKETS = 1000;
    localparam int IDLE_PCT       = 38;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_TAIL     = 2 * (2 * DVD_W + 7);
    localparam int CYCLE_LIMIT    = 600000;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               req_valid  = 1'b0;
    logic [SID_W-1:0]   req_stream = '0;
    logic [LEN_W-1:0]   req_bytes  = '0;
    logic [TIME_W-1:0]  req_now    = '0;
    logic               rsp_ready  = 1'b0;
    logic               req_ready;
    logic               rsp_valid;
    logic [SID_W-1:0]   rsp_stream;
    logic [INST_W-1:0]  rsp_instant;
    logic [AVG_W-1:0]   rsp_average;
    logic [LEN_W-1:0]   rsp_length;
    logic [TOTAL_W-1:0] rsp_total;

    int chk_errors;
    int chk_pending;

    // Shared pacing controls, written only by the stimulus process.
    bit no_idle    = 1'b0;
    int hold_token = 0;

    // Receiver side state.
    int hold_seen = 0;
    int hold_left = 0;
    int cycles    = 0;

    logic [TIME_W-1:0] stream_clock [STREAMS];

    packet_rate_meter_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .o_ready        (req_ready),
        .i_stream_id    (req_stream),
        .i_packet_bytes (req_bytes),
        .i_now_ms       (req_now),
        .o_valid        (rsp_valid),
        .i_ready        (rsp_ready),
        .o_stream_out   (rsp_stream),
        .o_instant_bps  (rsp_instant),
        .o_average_bps  (rsp_average),
        .o_length_echo  (rsp_length),
        .o_total_bytes  (rsp_total)
    );

    prm_rate_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req_stream  (req_stream),
        .i_req_bytes   (req_bytes),
        .i_req_now     (req_now),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_rsp_stream  (rsp_stream),
        .i_rsp_instant (rsp_instant),
        .i_rsp_average (rsp_average),
        .i_rsp_length  (rsp_length),
        .i_rsp_total   (rsp_total),
        .o_error_count (chk_errors),
        .o_pending     (chk_pending)
    );

    // Clock with a 2 ns period.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stalls, a free-running stretch, and a long hold-off on request.
    always @(posedge clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= RX_HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end else if (no_idle) begin
            rsp_ready <= 1'b1;
        end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offers one request after an optional random gap and waits for it to be taken.
    task automatic send_packet(input logic [SID_W-1:0] sid, input logic [LEN_W-1:0] len,
                               input logic [TIME_W-1:0] now);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_stream <= sid;
        req_bytes  <= len;
        req_now    <= now;
        do @(posedge clk); while (!req_ready);
    endtask

    // Stops offering and waits until every expected report has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (chk_pending != 0);
    endtask

    // Mostly steady per-stream timelines, with repeated stamps, zero stamps,
    // wrap-around, random jumps and dropped empty packets mixed in.
    task automatic send_random_packet(output bit counted);
        logic [SID_W-1:0]  sid;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] now;
        int unsigned       kind;

        sid  = SID_W'($urandom_range(STREAMS - 1));
        kind = $urandom_range(99);
        len  = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(64, 1))
                                        : LEN_W'($urandom_range(65535, 1));
        if (kind < 6) begin
            len = '0;
            now = $urandom();
        end else if (kind < 12) begin
            now = $urandom();
        end else if (kind < 16) begin
            now = stream_clock[sid];
        end else if (kind < 18) begin
            now = '0;
        end else if (kind < 21) begin
            now = 32'hFFFF_FFFF - $urandom_range(3000);
        end else if ($urandom_range(4) == 0) begin
            now = stream_clock[sid] + $urandom_range(200000, 1);
        end else begin
            now = stream_clock[sid] + $urandom_range(40, 1);
        end
        send_packet(sid, len, now);
        if (len != '0)
            stream_clock[sid] = now;
        counted = (len != '0);
    endtask

    initial begin
        int sent;
        bit counted;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: first packet with no previous stamp, zero span, dropped
        // empty packets, maximum length over one millisecond, repeated stamp,
        // timestamp wrap and a window filled past its length.
        send_packet(1'b0, 16'd1, 32'd0);
        send_packet(1'b0, 16'hFFFF, 32'd0);
        send_packet(1'b0, 16'd0, 32'd5);
        send_packet(1'b0, 16'hFFFF, 32'd1);
        send_packet(1'b0, 16'hFFFF, 32'd2);
        send_packet(1'b0, 16'd100, 32'd2);
        send_packet(1'b1, 16'd1000, 32'hFFFF_FFF0);
        send_packet(1'b1, 16'd1500, 32'h0000_0010);
        send_packet(1'b1, 16'd0, 32'hFFFF_FFFF);
        send_packet(1'b1, 16'd64, 32'hFFFF_FFFF);
        for (int k = 0; k < 12; k++)
            send_packet(1'b0, LEN_W'(1 + k * 5000), TIME_W'(10 + 3 * k));
        stream_clock[0] = 32'd43;
        stream_clock[1] = 32'hFFFF_FFFF;

        // Random part with a long result hold-off, two full drains and a
        // stretch with no idling on either side.
        sent = 0;
        while (sent < RANDOM_PACKETS) begin
            send_random_packet(counted);
            if (counted) begin
                sent++;
                if (sent == 150)
                    hold_token <= hold_token + 1;
                if (sent == 400 || sent == 800)
                    wait_drained();
                no_idle <= (sent >= 400 && sent < 600);
            end
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (chk_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ packet_rate_meter_unit.f @@
hdl/prm_pkg.sv
hdl/prm_divider.sv
hdl/prm_datapath.sv
hdl/prm_ctrl.sv
hdl/packet_rate_meter_unit.sv
dv/prm_rate_checker.sv
dv/tb_top.sv
